// ===== src/base64_stream_encoder_macros.svh =====
// assertion macros shared by the encoder modules
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
`define B64E_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define B64E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define B64E_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define B64E_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/b64e_pkg.sv =====
// types, constants and the alphabet lookup for the base64 encoder
`timescale 1ns / 1ps

package b64e_pkg;

	localparam int unsigned MAX_CHARS = 4;
	localparam logic [6:0] PAD_CHAR = 7'h3D;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic       last_char;
	} char_item_t;

	// characters produced by one byte, in order of output
	typedef struct packed {
		logic [MAX_CHARS-1:0][6:0] chars;
		logic [2:0]                n_chars;
		logic                      last;
	} char_rec_t;

	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] c;
		if (v < 6'd26) begin
			c = 7'h41 + {1'b0, v};
		end else if (v < 6'd52) begin
			c = 7'h61 + {1'b0, v - 6'd26};
		end else if (v < 6'd62) begin
			c = 7'h30 + {1'b0, v - 6'd52};
		end else if (v == 6'd62) begin
			c = 7'h2B;
		end else begin
			c = 7'h2F;
		end
		return c;
	endfunction

endpackage

// ===== src/b64e_front.sv =====
// front end: accepts bytes, splits them into sextets and builds a character record
`timescale 1ns / 1ps

module b64e_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_ready,
	input  b64e_pkg::byte_item_t   byte_item,
	input  logic                   queue_full,
	output logic                   rec_push,
	output b64e_pkg::char_rec_t    rec
);

	logic [3:0] leftover_bits_q;
	logic [2:0] leftover_count_q;
	logic [1:0] char_phase_q;

	logic [5:0] s0;
	logic [5:0] s1;
	logic [5:0] flush;
	logic [1:0] kdata;
	logic       has_rem;
	logic [3:0] nxt_bits;
	logic [2:0] nxt_count;
	logic [1:0] ndata;
	logic [1:0] phase_after;
	logic [1:0] pads;
	logic [2:0] total;
	logic [7:0] b;
	logic       last;

	assign b          = byte_item.data_byte;
	assign last       = byte_item.last_byte;
	assign byte_ready = !queue_full;
	assign rec_push   = byte_valid && byte_ready;

	always_comb begin
		s0        = '0;
		s1        = '0;
		flush     = '0;
		kdata     = 2'd1;
		has_rem   = 1'b0;
		nxt_bits  = '0;
		nxt_count = '0;
		case (leftover_count_q)
			3'd0: begin
				s0        = b[7:2];
				flush     = {b[1:0], 4'b0000};
				has_rem   = 1'b1;
				nxt_bits  = {2'b00, b[1:0]};
				nxt_count = 3'd2;
			end
			3'd2: begin
				s0        = {leftover_bits_q[1:0], b[7:4]};
				flush     = {b[3:0], 2'b00};
				has_rem   = 1'b1;
				nxt_bits  = b[3:0];
				nxt_count = 3'd4;
			end
			default: begin
				s0    = {leftover_bits_q, b[7:6]};
				s1    = b[5:0];
				kdata = 2'd2;
			end
		endcase
	end

	always_comb begin
		ndata       = kdata + {1'b0, last && has_rem};
		phase_after = char_phase_q + ndata;
		pads        = last ? (2'd0 - phase_after) : 2'd0;
		total       = {1'b0, ndata} + {1'b0, pads};
		if (total > 3'(b64e_pkg::MAX_CHARS)) begin
			total = 3'(b64e_pkg::MAX_CHARS);
		end
		rec.chars[0] = b64e_pkg::b64_char(s0);
		if (kdata == 2'd2) begin
			rec.chars[1] = b64e_pkg::b64_char(s1);
		end else if (ndata == 2'd2) begin
			rec.chars[1] = b64e_pkg::b64_char(flush);
		end else begin
			rec.chars[1] = b64e_pkg::PAD_CHAR;
		end
		rec.chars[2] = b64e_pkg::PAD_CHAR;
		rec.chars[3] = b64e_pkg::PAD_CHAR;
		rec.n_chars  = total;
		rec.last     = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leftover_bits_q  <= '0;
			leftover_count_q <= '0;
			char_phase_q     <= '0;
		end else if (rec_push) begin
			if (last) begin
				leftover_bits_q  <= '0;
				leftover_count_q <= '0;
				char_phase_q     <= '0;
			end else begin
				leftover_bits_q  <= nxt_bits;
				leftover_count_q <= nxt_count;
				char_phase_q     <= phase_after;
			end
		end
	end

endmodule

// ===== src/b64e_queue.sv =====
// short queue of character records between front and back end
`timescale 1ns / 1ps
`include "base64_stream_encoder_macros.svh"

module b64e_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  b64e_pkg::char_rec_t push_rec,
	output logic                full,
	input  logic                pop,
	output b64e_pkg::char_rec_t pop_rec,
	output logic                not_empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	b64e_pkg::char_rec_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_rec   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`B64E_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`B64E_ASSERT_NOW(a_pop_nonempty, clk, arst_n, pop, not_empty)
	`B64E_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

// ===== src/b64e_back.sv =====
// back end: plays out one character per cycle into the output register while char_ready does not stall it
`timescale 1ns / 1ps
`include "base64_stream_encoder_macros.svh"

module b64e_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rec_valid,
	input  b64e_pkg::char_rec_t  rec,
	output logic                 rec_pop,
	output logic                 char_valid,
	input  logic                 char_ready,
	output b64e_pkg::char_item_t char_item
);

	b64e_pkg::char_rec_t  cur_q;
	logic                 cur_valid_q;
	logic [1:0]           idx_q;
	logic                 out_valid_q;
	b64e_pkg::char_item_t out_item_q;

	logic       advance;
	logic       final_char;
	logic [2:0] idx_ext;

	assign idx_ext    = {1'b0, idx_q};
	assign advance    = cur_valid_q && (!out_valid_q || char_ready);
	assign final_char = (idx_ext == cur_q.n_chars - 3'd1);
	assign rec_pop    = rec_valid && (!cur_valid_q || (advance && final_char));
	assign char_valid = out_valid_q;
	assign char_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (char_ready) begin
				out_valid_q <= 1'b0;
			end
			if (rec_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else begin
				if (advance) begin
					idx_q <= idx_q + 2'd1;
				end
				if (advance && final_char) begin
					cur_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			cur_q <= rec;
		end
		if (advance) begin
			out_item_q.out_char  <= cur_q.chars[idx_q];
			out_item_q.last_char <= cur_q.last && final_char;
		end
	end

	`B64E_ASSERT_NOW(a_count_range, clk, arst_n, cur_valid_q,
		cur_q.n_chars != 3'd0 && cur_q.n_chars <= 3'(b64e_pkg::MAX_CHARS))
	`B64E_ASSERT_NOW(a_idx_range, clk, arst_n, cur_valid_q, idx_ext < cur_q.n_chars)
	`B64E_ASSERT_NEXT(a_rec_done, clk, arst_n, advance && final_char && !rec_pop, !cur_valid_q)

endmodule

// ===== src/base64_stream_encoder.sv =====
// top level of the streaming base64 encoder
//
//  channel  direction  handshake               payload
//  byte     in         byte_valid/byte_ready   byte_item (data_byte, last_byte)
//  char     out        char_valid/char_ready   char_item (out_char, last_char)
//
// a byte is taken every cycle while the record queue has room
// each byte yields one to four characters, one per cycle from the output register while char_ready allows
// sustained rate is set by the single-character output register: four characters per group of
// three bytes, and up to four characters for a final byte that needs padding
// reset clears the bit store and the character phase and empties the queue and the output register
// a stall on char_ready fills the queue and then drops byte_ready
`timescale 1ns / 1ps

module base64_stream_encoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  b64e_pkg::byte_item_t byte_item,
	output logic                 char_valid,
	input  logic                 char_ready,
	output b64e_pkg::char_item_t char_item
);

	b64e_pkg::char_rec_t front_rec;
	b64e_pkg::char_rec_t back_rec;
	logic                rec_push;
	logic                rec_pop;
	logic                queue_full;
	logic                queue_not_empty;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.queue_full (queue_full),
		.rec_push   (rec_push),
		.rec        (front_rec)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.push_rec  (front_rec),
		.full      (queue_full),
		.pop       (rec_pop),
		.pop_rec   (back_rec),
		.not_empty (queue_not_empty)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec_valid  (queue_not_empty),
		.rec        (back_rec),
		.rec_pop    (rec_pop),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item)
	);

endmodule

// ===== tb/base64_stream_encoder_tb.sv =====
// self-checking testbench for the streaming base64 encoder
`timescale 1ns / 1ps

module base64_stream_encoder_tb;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned RANDOM_BYTES = 150;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam bit [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef enum int unsigned {
		RX_FREE,
		RX_COIN,
		RX_ONE_IN_THREE,
		RX_LONG_STALLS
	} rx_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 byte_valid;
	logic                 byte_ready;
	b64e_pkg::byte_item_t byte_item;
	logic                 char_valid;
	logic                 char_ready;
	b64e_pkg::char_item_t char_item;

	b64e_pkg::char_item_t expected_chars[$];
	logic [3:0]           held_bits;
	logic [2:0]           held_count;
	logic [1:0]           out_phase;

	int unsigned errors;
	int unsigned cycles;
	int unsigned bytes_sent;
	int unsigned messages_sent;
	int unsigned chars_checked;
	int unsigned burst_left;
	int unsigned hold_request;
	bit          gaps_on;

	base64_stream_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	function automatic logic [6:0] sextet_to_ascii(input logic [5:0] v);
		return ALPHABET[8*(63-v) +: 7];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// expected characters for one accepted byte
	task automatic encode_byte(input logic [7:0] data, input logic last);
		logic [11:0]          acc;
		int unsigned          nbits;
		int unsigned          n;
		b64e_pkg::char_item_t group[4];
		acc = {held_bits, data};
		nbits = held_count + 8;
		n = 0;
		acc &= (12'd1 << nbits) - 12'd1;
		while (nbits >= 6) begin
			nbits -= 6;
			group[n] = '{out_char: sextet_to_ascii(6'((acc >> nbits) & 12'h3F)), last_char: 1'b0};
			n++;
			out_phase++;
		end
		acc &= (12'd1 << nbits) - 12'd1;
		if (last) begin
			if (nbits > 0) begin
				group[n] = '{out_char: sextet_to_ascii(6'((acc << (6 - nbits)) & 12'h3F)),
					last_char: 1'b0};
				n++;
				out_phase++;
			end
			while (out_phase != 2'd0 && n < 4) begin
				group[n] = '{out_char: b64e_pkg::PAD_CHAR, last_char: 1'b0};
				n++;
				out_phase++;
			end
			if (n > 0) begin
				group[n-1].last_char = 1'b1;
			end
			held_bits = 4'd0;
			held_count = 3'd0;
			out_phase = 2'd0;
		end else begin
			held_bits = acc[3:0];
			held_count = 3'(nbits);
		end
		for (int i = 0; i < n; i++) begin
			expected_chars.insert(expected_chars.size(), group[i]);
		end
	endtask

	task automatic idle_cycles(input int unsigned n);
		@(negedge clk);
		byte_valid <= 1'b0;
		byte_item <= b64e_pkg::byte_item_t'(9'($urandom));
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] data, input logic last);
		int unsigned gap;
		if (gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(0, 5);
				if (gap > 0) begin
					idle_cycles(gap);
				end
			end
			burst_left--;
		end
		@(negedge clk);
		byte_item <= '{data_byte: data, last_byte: last};
		byte_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (byte_ready) begin
				break;
			end
		end
		encode_byte(data, last);
		bytes_sent++;
		if (last) begin
			messages_sent++;
		end
	endtask

	task automatic send_random_message(input int unsigned len);
		logic [7:0] data;
		int unsigned kind;
		for (int unsigned i = 0; i < len; i++) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				data = 8'h00;
			end else if (kind == 1) begin
				data = 8'hFF;
			end else begin
				data = 8'($urandom);
			end
			send_byte(data, i == len - 1);
		end
	endtask

	task automatic test_directed();
		gaps_on = 1'b0;
		// one byte messages: two characters and two pads
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		// two byte message: three characters and one pad
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b1);
		// three byte messages with no padding, alphabet extremes
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFB, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBE, 1'b1);
		// four and five byte messages across a group boundary
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h6E, 1'b0);
		send_byte(8'hA5, 1'b1);
		send_byte(8'h5A, 1'b0);
		send_byte(8'h0F, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b1);
	endtask

	task automatic test_random_messages();
		int unsigned start;
		int unsigned len;
		gaps_on = 1'b1;
		burst_left = 0;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			if ($urandom_range(0, 9) < 7) begin
				len = $urandom_range(1, 6);
			end else begin
				len = $urandom_range(7, 20);
			end
			send_random_message(len);
		end
	endtask

	task automatic test_back_pressure();
		gaps_on = 1'b0;
		idle_cycles(1);
		hold_request = HOLD_OFF_CYCLES;
		for (int i = 0; i < 4; i++) begin
			send_random_message($urandom_range(4, 10));
		end
	endtask

	// receiver stalls in randomly chosen modes, with an optional long hold-off
	initial begin : receiver
		int unsigned hold_left;
		int unsigned mode_left;
		int unsigned stall_left;
		int unsigned tick;
		rx_mode_t    mode;
		hold_left = 0;
		mode_left = 0;
		stall_left = 0;
		tick = 0;
		mode = RX_FREE;
		char_ready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(32, 96);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				char_ready <= 1'b0;
			end else begin
				case (mode)
					RX_FREE: begin
						char_ready <= 1'b1;
					end
					RX_COIN: begin
						char_ready <= 1'($urandom);
					end
					RX_ONE_IN_THREE: begin
						char_ready <= (tick % 3) == 0;
					end
					default: begin
						if (stall_left > 0) begin
							stall_left--;
							char_ready <= 1'b0;
						end else begin
							char_ready <= 1'b1;
							if ($urandom_range(0, 7) == 0) begin
								stall_left = $urandom_range(4, 12);
							end
						end
					end
				endcase
			end
		end
	end

	// compare every accepted character with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && char_valid && char_ready) begin
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected character 0x%02h last %0b",
					char_item.out_char, char_item.last_char));
			end else begin
				if (char_item.out_char !== expected_chars[0].out_char) begin
					report_mismatch($sformatf("out_char 0x%02h, want 0x%02h",
						char_item.out_char, expected_chars[0].out_char));
				end
				if (char_item.last_char !== expected_chars[0].last_char) begin
					report_mismatch($sformatf("last_char %0b, want %0b",
						char_item.last_char, expected_chars[0].last_char));
				end
				void'(expected_chars.pop_front());
				chars_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d characters outstanding", expected_chars.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_item = '0;
		errors = 0;
		cycles = 0;
		bytes_sent = 0;
		messages_sent = 0;
		chars_checked = 0;
		burst_left = 0;
		hold_request = 0;
		gaps_on = 1'b0;
		held_bits = 4'd0;
		held_count = 3'd0;
		out_phase = 2'd0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_messages();
		test_back_pressure();

		idle_cycles(1);
		while (expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_chars.size() != 0) begin
			report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
		end

		$display("encoded %0d bytes in %0d messages, %0d characters checked",
			bytes_sent, messages_sent, chars_checked);
		$display("covered all padding lengths, bursty input, stalled output and a full queue");
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== base64_stream_encoder.f =====
+incdir+src
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_stream_encoder.sv
tb/base64_stream_encoder_tb.sv
